/* rtl/core/aes128_block_encrypt_macros.svh */
// Assertion helpers for the AES-128 core
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define AES_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/aes_pkg.sv */
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumStages = NumRounds + 1;

  typedef logic [127:0] aes_block_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  typedef enum logic {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } aes_cfg_idx_e;

  localparam logic [7:0] RoundConst [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam logic [7:0] SubTab [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // byte i of the state sits at bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(aes_block_t b, int unsigned i);
    return b[127 - 8 * i -: 8];
  endfunction

endpackage

/* rtl/core/aes_round_cell.sv */
module aes_round_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  aes_pkg::aes_block_t state_i,
  input  aes_pkg::aes_block_t key_i,
  input  logic [7:0]        rcon_i,
  input  logic              last_i,
  output logic              valid_o,
  output aes_pkg::aes_block_t state_o,
  output aes_pkg::aes_block_t key_o
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] nk [16];
  aes_block_t state_d, key_d, state_q, key_q;
  logic valid_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = get_byte(state_i, i);
      k[i] = get_byte(key_i, i);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4 * c + r] = SubTab[s[4 * ((c + r) % 4) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last_i) begin
        m[4 * c] = a0;
        m[4 * c + 1] = a1;
        m[4 * c + 2] = a2;
        m[4 * c + 3] = a3;
      end else begin
        m[4 * c] = a0 ^ all ^ gf_dbl(a0 ^ a1);
        m[4 * c + 1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
        m[4 * c + 2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
        m[4 * c + 3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
      end
    end
    nk[0] = k[0] ^ SubTab[k[13]] ^ rcon_i;
    nk[1] = k[1] ^ SubTab[k[14]];
    nk[2] = k[2] ^ SubTab[k[15]];
    nk[3] = k[3] ^ SubTab[k[12]];
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i - 4];
    end
    for (int i = 0; i < 16; i++) begin
      key_d[127 - 8 * i -: 8] = nk[i];
      state_d[127 - 8 * i -: 8] = m[i] ^ nk[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= state_d;
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o = key_q;
endmodule

/* rtl/core/aes128_block_encrypt.sv */
// AES-128 block encryption core.
// Input channel: in_valid_i / in_stall_o carry one plaintext word per
// accepted cycle (plain_high holds bytes 0..7, byte 0 in the top bits).
// Output channel: out_valid_o / out_stall_i carry one ciphertext word.
// Key: write cfg_we_i with cfg_idx_i 0 (key_high) or 1 (key_low) while idle.
// Structure: one input stage adding the first round key, then a row of ten
// round cells, each holding one block and its round key and passing both on.
// Path: an accepted word is registered in the input stage, then in each round
// cell in turn, and is then shown on out_valid_o / out_data_o.
// Throughput: one word per cycle while the output is not stalled; every round is combinational within its cell.
// When the receiver stalls, the full stages hold; an empty stage still
// fills, so in_stall_o rises only when every stage holds a word.
// Reset clears all valid flags and sets the key to zero.
`include "aes128_block_encrypt_macros.svh"

module aes128_block_encrypt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aes_pkg::aes_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aes_pkg::aes_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_data_i
);
  import aes_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic        v [1:NumStages];
  aes_block_t  st [1:NumStages];
  aes_block_t  ky [1:NumStages];
  logic        adv [NumStages];
  logic        v0_q;
  aes_block_t  st0_q, ky0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (aes_cfg_idx_e'(cfg_idx_i))
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage k advances when stage k is empty or the next stage advances
  always_comb begin
    adv[NumStages - 1] = !v[NumStages] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !v[i + 1] || adv[i + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ky0_q <= {key_hi_q, key_lo_q};
      st0_q <= {in_data_i.plain_high, in_data_i.plain_low} ^ {key_hi_q, key_lo_q};
    end
  end

  assign v[1] = v0_q;
  assign st[1] = st0_q;
  assign ky[1] = ky0_q;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk_i,
      .rst_ni,
      .adv_i   (adv[g + 1]),
      .valid_i (v[g + 1]),
      .state_i (st[g + 1]),
      .key_i   (ky[g + 1]),
      .rcon_i  (RoundConst[g]),
      .last_i  (g == NumRounds - 1),
      .valid_o (v[g + 2]),
      .state_o (st[g + 2]),
      .key_o   (ky[g + 2])
    );
  end

  assign in_stall_o = !adv[0];
  assign out_valid_o = v[NumStages];
  assign out_data_o.cipher_high = st[NumStages][127:64];
  assign out_data_o.cipher_low = st[NumStages][63:0];

  `AES_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o),
    "stalled output word changed")
  `AES_ASSERT(a_stall_full, in_stall_o |-> out_valid_o && out_stall_i,
    "input stalled while pipeline can move")
  `AES_ASSERT_NEXT(a_fill, in_valid_i && !in_stall_o, v[1], "accepted word not captured")
endmodule
